@@ sv/vfcm_pkg.sv @@
// vfcm_pkg: shared types and constants for the voxel face culling mesher
// request/result item structs, state encoding, controller command and status
// no dependencies
package vfcm_pkg;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_MESH  = 2'd2
	} req_code_t;

	localparam logic       KIND_VERTEX = 1'b0;
	localparam logic       KIND_READ   = 1'b1;
	localparam logic [2:0] VTX_LAST    = 3'd5;
	localparam logic [2:0] SCAN_END    = 3'd6;
	localparam int         NUM_FACES   = 6;
	localparam int         COORD_W     = 7;

	// corner offsets per face and vertex, packed {dx, dy, dz}
	localparam logic [2:0] FACE_CORNERS [NUM_FACES][6] = '{
		'{3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011},
		'{3'b100, 3'b110, 3'b101, 3'b110, 3'b111, 3'b101},
		'{3'b100, 3'b000, 3'b010, 3'b010, 3'b110, 3'b100},
		'{3'b001, 3'b101, 3'b011, 3'b011, 3'b101, 3'b111},
		'{3'b000, 3'b100, 3'b001, 3'b001, 3'b100, 3'b101},
		'{3'b010, 3'b011, 3'b110, 3'b110, 3'b011, 3'b111}
	};

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] cell_x;
		logic [3:0] cell_y;
		logic [3:0] cell_z;
		logic [6:0] cell_value;
	} req_t;

	typedef struct packed {
		logic              result_kind;
		logic [4:0]        vert_x;
		logic [4:0]        vert_y;
		logic [4:0]        vert_z;
		logic signed [7:0] vert_attr;
		logic [2:0]        face_code;
		logic [6:0]        read_value;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CENTER,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic accept_en;
		logic rd_src_nb;
		logic rd_en;
		logic read_load;
		logic center_load;
		logic scan_step;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic fire_read;
		logic fire_mesh;
		logic center_empty;
		logic scan_done;
		logic mask_empty;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

@@ sv/voxel_face_culling_mesher.sv @@
// voxel_face_culling_mesher: 3-D cube grid with write, read and face-culled mesh requests
// after reset the store is cleared one cell a cycle, all 2^(clog2 SX + clog2 SY + clog2 SZ)
// cells (4096 by default), with req_stall high; a write is stored when accepted, a read
// registers the cell, then loads its item once the output is free; mesh reads the cell,
// scans the six neighbors through the single-port cell store, then gives one vertex item
// per cycle while the output is not stalled; one request is worked on at a time
module voxel_face_culling_mesher #(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vfcm_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output vfcm_pkg::res_t res
);
	import vfcm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	vfcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	vfcm_dp #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

@@ sv/vfcm_ctrl.sv @@
// vfcm_ctrl: sequencing state machine of the voxel mesher
// drives datapath commands from datapath status; uses vfcm_pkg
module vfcm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  vfcm_pkg::stat_t stat,
	output vfcm_pkg::cmd_t  cmd
);
	import vfcm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (stat.fire_read) state_nxt = ST_READ;
				else if (stat.fire_mesh) state_nxt = ST_CENTER;
			end
			ST_READ: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			ST_CENTER: begin
				if (stat.center_empty) state_nxt = ST_IDLE;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.mask_empty) state_nxt = ST_IDLE;
				else if (stat.out_free && stat.emit_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.accept_en = 1'b1;
				cmd.rd_en     = 1'b1;
			end
			ST_READ: begin
				cmd.read_load = stat.out_free;
			end
			ST_CENTER: begin
				cmd.center_load = !stat.center_empty;
			end
			ST_SCAN: begin
				cmd.rd_src_nb = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.scan_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit_load = stat.out_free && !stat.mask_empty;
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ sv/vfcm_dp.sv @@
// vfcm_dp: datapath of the voxel mesher
// cell store, request and scan registers, vertex generation, output register
// uses vfcm_pkg; commanded by vfcm_ctrl
module vfcm_dp #(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vfcm_pkg::cmd_t  cmd,
	output vfcm_pkg::stat_t stat,
	input  logic            req_valid,
	output logic            req_stall,
	input  vfcm_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_stall,
	output vfcm_pkg::res_t  res
);
	import vfcm_pkg::*;

	localparam int XW    = $clog2(SIZE_X);
	localparam int YW    = $clog2(SIZE_Y);
	localparam int ZW    = $clog2(SIZE_Z);
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;
	localparam logic [COORD_W-1:0] SX = COORD_W'(SIZE_X);
	localparam logic [COORD_W-1:0] SY = COORD_W'(SIZE_Y);
	localparam logic [COORD_W-1:0] SZ = COORD_W'(SIZE_Z);

	logic [6:0]          mem [DEPTH];
	logic [6:0]          rd_q;
	logic [AW-1:0]       clr_q;
	logic [3:0]          x_q, y_q, z_q;
	logic                inside_q;
	logic [6:0]          type_q;
	logic [2:0]          scan_q;
	logic                nb_in_q;
	logic [5:0]          mask_q;
	logic [2:0]          vtx_q;
	logic                out_valid_q;
	res_t                res_q;

	logic [COORD_W-1:0]  ix, iy, iz;
	logic                in_inside;
	logic                fire;
	logic                wr;
	logic [AW-1:0]       in_addr;
	logic [COORD_W-1:0]  nx, ny, nz;
	logic                nb_in;
	logic [AW-1:0]       nb_addr;
	logic [AW-1:0]       addr;
	logic                we;
	logic [2:0]          face;
	logic [2:0]          corner;
	logic                out_free;

	// request address and grid check
	assign ix        = COORD_W'(req.cell_x);
	assign iy        = COORD_W'(req.cell_y);
	assign iz        = COORD_W'(req.cell_z);
	assign in_inside = (ix < SX) && (iy < SY) && (iz < SZ);
	assign in_addr   = {ix[XW-1:0], iy[YW-1:0], iz[ZW-1:0]};
	assign fire      = req_valid && cmd.accept_en;
	assign wr        = fire && (req.req_type == REQ_WRITE) && in_inside;
	assign req_stall = !cmd.accept_en;

	// neighbor of the face under scan, below zero wraps out of range
	always_comb begin
		nx = COORD_W'(x_q);
		ny = COORD_W'(y_q);
		nz = COORD_W'(z_q);
		unique case (scan_q)
			3'd0:    nx = COORD_W'(x_q) - COORD_W'(1);
			3'd1:    nx = COORD_W'(x_q) + COORD_W'(1);
			3'd2:    nz = COORD_W'(z_q) - COORD_W'(1);
			3'd3:    nz = COORD_W'(z_q) + COORD_W'(1);
			3'd4:    ny = COORD_W'(y_q) - COORD_W'(1);
			3'd5:    ny = COORD_W'(y_q) + COORD_W'(1);
			default: nx = COORD_W'(x_q);
		endcase
	end
	assign nb_in   = (nx < SX) && (ny < SY) && (nz < SZ);
	assign nb_addr = {nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]};

	// single-port cell store
	always_comb begin
		priority if (cmd.clr_en) addr = clr_q;
		else if (cmd.rd_src_nb) addr = nb_addr;
		else addr = in_addr;
	end
	assign we = cmd.clr_en || wr;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= cmd.clr_en ? 7'd0 : req.cell_value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (fire) begin
			x_q      <= req.cell_x;
			y_q      <= req.cell_y;
			z_q      <= req.cell_z;
			inside_q <= in_inside;
		end
		if (cmd.center_load) begin
			type_q <= rd_q;
		end
	end

	// lowest open face still to emit
	always_comb begin
		face = 3'd0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (mask_q[i]) face = 3'(i);
		end
	end
	assign corner = FACE_CORNERS[face][vtx_q];

	// neighbor scan and emit bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			nb_in_q <= 1'b0;
			mask_q  <= '0;
			vtx_q   <= '0;
		end else begin
			if (cmd.center_load) begin
				scan_q <= '0;
				mask_q <= '0;
				vtx_q  <= '0;
			end
			if (cmd.scan_step) begin
				if (scan_q != 3'd0) begin
					mask_q[3'(scan_q - 3'd1)] <= !(nb_in_q && (rd_q != 7'd0));
				end
				nb_in_q <= nb_in;
				scan_q  <= scan_q + 3'd1;
			end
			if (cmd.emit_load) begin
				if (vtx_q == VTX_LAST) begin
					vtx_q        <= '0;
					mask_q[face] <= 1'b0;
				end else begin
					vtx_q <= vtx_q + 3'd1;
				end
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.read_load || cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_load) begin
			res_q.result_kind <= KIND_READ;
			res_q.vert_x      <= '0;
			res_q.vert_y      <= '0;
			res_q.vert_z      <= '0;
			res_q.vert_attr   <= '0;
			res_q.face_code   <= '0;
			res_q.read_value  <= inside_q ? rd_q : 7'd0;
			res_q.last        <= 1'b1;
		end else if (cmd.emit_load) begin
			res_q.result_kind <= KIND_VERTEX;
			res_q.vert_x      <= 5'(x_q) + 5'(corner[2]);
			res_q.vert_y      <= 5'(y_q) + 5'(corner[1]);
			res_q.vert_z      <= 5'(z_q) + 5'(corner[0]);
			res_q.vert_attr   <= (face >= 3'd4) ? 8'(8'd0 - {1'b0, type_q})
			                                    : 8'({1'b0, type_q});
			res_q.face_code   <= face;
			res_q.read_value  <= 7'd0;
			res_q.last        <= stat.emit_last;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	// status to the controller
	always_comb begin
		stat              = '0;
		stat.clr_last     = &clr_q;
		stat.fire_read    = fire && (req.req_type == REQ_READ);
		stat.fire_mesh    = fire && (req.req_type == REQ_MESH) && in_inside;
		stat.center_empty = (rd_q == 7'd0);
		stat.scan_done    = (scan_q == SCAN_END);
		stat.mask_empty   = (mask_q == 6'd0);
		stat.emit_last    = (vtx_q == VTX_LAST) && ((mask_q & (mask_q - 6'd1)) == 6'd0);
		stat.out_free     = out_free;
	end

endmodule
